// ===== sv/sdar_pkg.sv =====
// ----------------------------------------------------------------------------
// sdar_pkg
// Shared types and constants for the stick direction / auto-repeat block.
// ----------------------------------------------------------------------------
package sdar_pkg;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_VERT_CODE    = 2'd0,
      CSR_HORIZ_CODE   = 2'd1,
      CSR_REPEAT_DELAY = 2'd2,
      CSR_REPEAT_PER   = 2'd3
   } csr_index_type;

   localparam int CODE_W  = 6;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 16;
   localparam int LOAD_W  = 16;
   localparam int STEP_W  = 2;

   localparam logic signed [VALUE_W-1:0] SNAP_HIGH = 16'sd16383;
   localparam logic signed [VALUE_W-1:0] SNAP_LOW  = -16'sd16384;

   localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
   localparam logic signed [STEP_W-1:0] STEP_POS  = 2'sb01;
   localparam logic signed [STEP_W-1:0] STEP_NEG  = 2'sb11;

   localparam logic signed [CODE_W-1:0] VERT_CODE_RESET  = 6'sd2;
   localparam logic signed [CODE_W-1:0] HORIZ_CODE_RESET = 6'sd1;
   localparam logic [LOAD_W-1:0]        DELAY_RESET      = 16'd250;
   localparam logic [LOAD_W-1:0]        PERIOD_RESET     = 16'd50;

   // per-axis event decoded from one beat
   typedef struct packed {
      logic hit;   // sample on this axis
      logic tick;  // millisecond tick
      logic pos;   // snapped value is full scale positive
      logic neg;   // snapped value is full scale negative
   } axis_evt_type;

endpackage

// ===== sv/stick_direction_with_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// stick_direction_with_auto_repeat
// Analog stick direction detector with per-axis key-style auto-repeat.
// ----------------------------------------------------------------------------
// Request channel (req_*): one beat is a motion sample (command 0) or a
// one millisecond tick (command 1). Response channel (rsp_*): exactly one
// beat per request, carrying a vertical and a horizontal step of -1/0/+1.
// Both channels use valid/stall; the receiver drives stall.
// An accepted request beat first loads the input register; the
// hysteresis/counter update then lands in the response register once it
// can advance. Throughput is one
// beat per cycle; a request is taken while a response waits, and req_stall
// rises only when both registers are full and rsp_stall is high. Axis
// state updates as the beat enters the response register, so consecutive
// beats see each other's effect.
// CSR port (csr_*): four registers, always ready; write only while idle.
// Synchronous reset clears both axis positions, repeat counters and the
// pipeline valids, and loads the register defaults.
// ----------------------------------------------------------------------------
module stick_direction_with_auto_repeat #(
   parameter int TICK_COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [0:0]                             req_command,
   input  logic [sdar_pkg::INDEX_W-1:0]           req_axis_index,
   input  logic signed [sdar_pkg::VALUE_W-1:0]    req_axis_value,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sdar_pkg::STEP_W-1:0]     rsp_vertical_step,
   output logic signed [sdar_pkg::STEP_W-1:0]     rsp_horizontal_step,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [sdar_pkg::LOAD_W-1:0]            csr_data
);

   logic                                in_valid_ff;
   sdar_pkg::cmd_type                   in_cmd_ff;
   logic [sdar_pkg::INDEX_W-1:0]        in_idx_ff;
   logic signed [sdar_pkg::VALUE_W-1:0] in_val_ff;

   logic                                rsp_valid_ff;
   logic signed [sdar_pkg::STEP_W-1:0]  vert_step_ff;
   logic signed [sdar_pkg::STEP_W-1:0]  horiz_step_ff;
   logic signed [sdar_pkg::STEP_W-1:0]  vert_step_in;
   logic signed [sdar_pkg::STEP_W-1:0]  horiz_step_in;

   logic signed [sdar_pkg::CODE_W-1:0]  vert_code_ff;
   logic signed [sdar_pkg::CODE_W-1:0]  horiz_code_ff;
   logic [sdar_pkg::LOAD_W-1:0]         delay_ff;
   logic [sdar_pkg::LOAD_W-1:0]         period_ff;

   sdar_pkg::axis_evt_type              vert_evt;
   sdar_pkg::axis_evt_type              horiz_evt;
   sdar_pkg::csr_index_type             csr_sel;

   logic advance;
   logic update;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign update    = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign csr_ready = 1'b1;
   assign csr_sel   = sdar_pkg::csr_index_type'(csr_index);

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         vert_code_ff  <= sdar_pkg::VERT_CODE_RESET;
         horiz_code_ff <= sdar_pkg::HORIZ_CODE_RESET;
         delay_ff      <= sdar_pkg::DELAY_RESET;
         period_ff     <= sdar_pkg::PERIOD_RESET;
      end else if (csr_valid & csr_ready) begin
         unique case (csr_sel)
            sdar_pkg::CSR_VERT_CODE:    vert_code_ff  <= csr_data[sdar_pkg::CODE_W-1:0];
            sdar_pkg::CSR_HORIZ_CODE:   horiz_code_ff <= csr_data[sdar_pkg::CODE_W-1:0];
            sdar_pkg::CSR_REPEAT_DELAY: delay_ff      <= csr_data;
            sdar_pkg::CSR_REPEAT_PER:   period_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (~req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall) begin
         in_cmd_ff <= sdar_pkg::cmd_type'(req_command);
         in_idx_ff <= req_axis_index;
         in_val_ff <= req_axis_value;
      end
   end

   sdar_classify u_classify (
      .command    (in_cmd_ff),
      .axis_index (in_idx_ff),
      .axis_value (in_val_ff),
      .vert_code  (vert_code_ff),
      .horiz_code (horiz_code_ff),
      .vert_evt   (vert_evt),
      .horiz_evt  (horiz_evt)
   );

   sdar_axis #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_vert (
      .clock         (clock),
      .reset         (reset),
      .enable        (update),
      .evt           (vert_evt),
      .repeat_delay  (delay_ff),
      .repeat_period (period_ff),
      .step          (vert_step_in)
   );

   sdar_axis #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_horiz (
      .clock         (clock),
      .reset         (reset),
      .enable        (update),
      .evt           (horiz_evt),
      .repeat_delay  (delay_ff),
      .repeat_period (period_ff),
      .step          (horiz_step_in)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         vert_step_ff  <= vert_step_in;
         horiz_step_ff <= horiz_step_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertical_step   = vert_step_ff;
   assign rsp_horizontal_step = horiz_step_ff;

   a_stall_needs_beat : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline slot");

   a_beat_reaches_rsp : assert property (@(posedge clock) disable iff (reset)
      update |=> rsp_valid_ff)
      else $error("beat lost between input and response register");

   a_sample_one_axis : assert property (@(posedge clock) disable iff (reset)
      (update && in_cmd_ff == sdar_pkg::CMD_SAMPLE)
         |=> !(vert_step_ff != sdar_pkg::STEP_NONE && horiz_step_ff != sdar_pkg::STEP_NONE))
      else $error("motion sample stepped both axes");

   a_step_code_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (vert_step_ff != 2'sb10 && horiz_step_ff != 2'sb10))
      else $error("illegal step code");

endmodule

// ===== sv/sdar_classify.sv =====
// ----------------------------------------------------------------------------
// sdar_classify
// Matches a sample to an axis, applies the sign flip and snaps the value.
// ----------------------------------------------------------------------------
module sdar_classify (
   input  sdar_pkg::cmd_type                         command,
   input  logic [sdar_pkg::INDEX_W-1:0]              axis_index,
   input  logic signed [sdar_pkg::VALUE_W-1:0]       axis_value,
   input  logic signed [sdar_pkg::CODE_W-1:0]        vert_code,
   input  logic signed [sdar_pkg::CODE_W-1:0]        horiz_code,
   output sdar_pkg::axis_evt_type                    vert_evt,
   output sdar_pkg::axis_evt_type                    horiz_evt
);

   logic [sdar_pkg::CODE_W-1:0] vert_mag;
   logic [sdar_pkg::CODE_W-1:0] horiz_mag;
   logic [sdar_pkg::CODE_W-1:0] index_plus_one;
   logic                        vert_match;
   logic                        horiz_match;
   logic                        sgn_pos;
   logic                        sgn_neg;
   logic                        is_high;
   logic                        is_low;
   logic                        sample;
   logic                        snap_pos;
   logic                        snap_neg;

   assign vert_mag  = vert_code[sdar_pkg::CODE_W-1] ? sdar_pkg::CODE_W'(-vert_code)
                                                     : sdar_pkg::CODE_W'(vert_code);
   assign horiz_mag = horiz_code[sdar_pkg::CODE_W-1] ? sdar_pkg::CODE_W'(-horiz_code)
                                                       : sdar_pkg::CODE_W'(horiz_code);
   assign index_plus_one = sdar_pkg::CODE_W'(axis_index) + sdar_pkg::CODE_W'(1);

   // zero code has magnitude zero and never matches
   assign vert_match  = (vert_mag == index_plus_one);
   assign horiz_match = (horiz_mag == index_plus_one);

   // horizontal code wins the sign when both name the same axis
   always_comb begin
      priority if (horiz_match) begin
         sgn_pos = ~horiz_code[sdar_pkg::CODE_W-1] & (horiz_code != '0);
         sgn_neg = horiz_code[sdar_pkg::CODE_W-1];
      end else if (vert_match) begin
         sgn_pos = ~vert_code[sdar_pkg::CODE_W-1] & (vert_code != '0);
         sgn_neg = vert_code[sdar_pkg::CODE_W-1];
      end else begin
         sgn_pos = 1'b0;
         sgn_neg = 1'b0;
      end
   end

   assign is_high  = (axis_value > sdar_pkg::SNAP_HIGH);
   assign is_low   = (axis_value < sdar_pkg::SNAP_LOW);
   assign snap_pos = (is_high & sgn_pos) | (is_low & sgn_neg);
   assign snap_neg = (is_high & sgn_neg) | (is_low & sgn_pos);
   assign sample   = (command == sdar_pkg::CMD_SAMPLE);

   // vertical detector takes precedence on a shared axis
   always_comb begin
      vert_evt.hit   = sample & vert_match;
      vert_evt.tick  = ~sample;
      vert_evt.pos   = snap_pos;
      vert_evt.neg   = snap_neg;
      horiz_evt.hit  = sample & horiz_match & ~vert_match;
      horiz_evt.tick = ~sample;
      horiz_evt.pos  = snap_pos;
      horiz_evt.neg  = snap_neg;
   end

endmodule

// ===== sv/sdar_axis.sv =====
// ----------------------------------------------------------------------------
// sdar_axis
// Hysteresis position and auto-repeat counter for one axis.
// ----------------------------------------------------------------------------
module sdar_axis #(
   parameter int TICK_COUNT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  sdar_pkg::axis_evt_type                evt,
   input  logic [sdar_pkg::LOAD_W-1:0]           repeat_delay,
   input  logic [sdar_pkg::LOAD_W-1:0]           repeat_period,
   output logic signed [sdar_pkg::STEP_W-1:0]    step
);

   localparam logic [32:0] CountMax = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;

   logic signed [sdar_pkg::STEP_W-1:0] position_ff;
   logic signed [sdar_pkg::STEP_W-1:0] position_in;
   logic                               armed_ff;
   logic                               armed_in;
   logic [TICK_COUNT_WIDTH-1:0]        ticks_left_ff;
   logic [TICK_COUNT_WIDTH-1:0]        ticks_left_in;
   logic [TICK_COUNT_WIDTH-1:0]        delay_load;
   logic [TICK_COUNT_WIDTH-1:0]        period_load;

   function automatic logic [TICK_COUNT_WIDTH-1:0] load_value(
      input logic [sdar_pkg::LOAD_W-1:0] v
   );
      logic [32:0] v_wide;
      v_wide = 33'(v);
      if (v == '0) begin
         return TICK_COUNT_WIDTH'(1);
      end else if (v_wide > CountMax) begin
         return CountMax[TICK_COUNT_WIDTH-1:0];
      end else begin
         return v_wide[TICK_COUNT_WIDTH-1:0];
      end
   endfunction

   assign delay_load  = load_value(repeat_delay);
   assign period_load = load_value(repeat_period);

   always_comb begin
      position_in   = position_ff;
      armed_in      = armed_ff;
      ticks_left_in = ticks_left_ff;
      step          = sdar_pkg::STEP_NONE;
      if (evt.tick) begin
         if (armed_ff) begin
            if (ticks_left_ff <= TICK_COUNT_WIDTH'(1)) begin
               ticks_left_in = period_load;
               step          = position_ff;
            end else begin
               ticks_left_in = ticks_left_ff - TICK_COUNT_WIDTH'(1);
            end
         end
      end else if (evt.hit) begin
         priority if (evt.pos) begin
            if (position_ff != sdar_pkg::STEP_POS) begin
               position_in   = sdar_pkg::STEP_POS;
               armed_in      = 1'b1;
               ticks_left_in = delay_load;
               step          = sdar_pkg::STEP_POS;
            end
         end else if (evt.neg) begin
            if (position_ff != sdar_pkg::STEP_NEG) begin
               position_in   = sdar_pkg::STEP_NEG;
               armed_in      = 1'b1;
               ticks_left_in = delay_load;
               step          = sdar_pkg::STEP_NEG;
            end
         end else begin
            position_in = sdar_pkg::STEP_NONE;
            armed_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= sdar_pkg::STEP_NONE;
         armed_ff      <= 1'b0;
         ticks_left_ff <= '0;
      end else if (enable) begin
         position_ff   <= position_in;
         armed_ff      <= armed_in;
         ticks_left_ff <= ticks_left_in;
      end
   end

endmodule
